// ===== hdl/otum_pkg.sv =====
// Shared constants, types and helper functions for the odometer telemetry UART mux.
// No dependencies; the ring, scheduler, top level and testbench import this package.

package otum_pkg;

    // Receive ring geometry.
    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    // Telemetry frame layout.
    localparam logic [2:0] FRAME_LEN = 3'd6;
    localparam int         COUNT_W   = 12;
    localparam int         TS_W      = 16;

    // Configuration reset values and the gap timer limit.
    localparam logic [7:0] GAP_RESET   = 8'd170;
    localparam logic [3:0] RATIO_RESET = 4'd3;
    localparam logic [7:0] GAP_MAX     = 8'd255;

    // Configuration register indexes.
    typedef enum logic {
        CFG_FRAME_GAP  = 1'b0,
        CFG_PASS_RATIO = 1'b1
    } t_cfg_reg;

    // Ring status seen by the scheduler for the word being accepted.
    typedef struct packed {
        logic nonempty;  // ring holds data once this word's byte is stored
        logic dropped;   // incoming byte is lost because the ring is full
        logic fwd;       // ring was empty, so a pop takes the incoming byte
    } t_ring_stat;

    // Advance a ring pointer with wrap at the ring depth.
    function automatic logic [RING_AW-1:0] ptr_inc(input logic [RING_AW-1:0] ptr);
        logic [RING_AW-1:0] nxt;
        if (ptr == RING_AW'(RING_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    // One byte of the telemetry frame built from a count and a timestamp.
    function automatic logic [7:0] frame_byte(input logic [COUNT_W-1:0] cnt,
                                              input logic [TS_W-1:0]    ts,
                                              input logic [2:0]         idx);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] chk;
        logic [7:0] res;
        b0  = {2'b11, cnt[11:6]};
        b1  = {2'b11, cnt[5:0]};
        b2  = {4'b1100, ts[15:12]};
        b3  = {2'b11, ts[11:6]};
        b4  = {2'b11, ts[5:0]};
        chk = b0 ^ b1 ^ b2 ^ b3 ^ b4;
        chk = {2'b10, chk[5:0]};
        case (idx)
            3'd0:    res = b0;
            3'd1:    res = b1;
            3'd2:    res = b2;
            3'd3:    res = b3;
            3'd4:    res = b4;
            default: res = chk;
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/otum_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.

module otum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/otum_ring.sv =====
// Receive ring: head, tail and fill bookkeeping around the ring RAM.
// Depends on otum_pkg and otum_ram.

module otum_ring
    import otum_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic       i_rx_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_pop,
    output t_ring_stat o_stat,
    output logic [7:0] o_rdata
);

    logic [RING_AW-1:0] r_head;
    logic [RING_AW-1:0] r_tail;
    logic [FILL_W-1:0]  r_fill;
    logic [RING_AW-1:0] n_head;
    logic [RING_AW-1:0] n_tail;
    logic [FILL_W-1:0]  n_fill;
    logic               full;
    logic               push;
    logic               ram_re;

    // Status for the word being accepted.
    assign full            = (r_fill == FILL_W'(RING_DEPTH));
    assign push            = i_acc && i_rx_valid && !full;
    assign o_stat.dropped  = i_rx_valid && full;
    assign o_stat.nonempty = (r_fill != '0) || (i_rx_valid && !full);
    assign o_stat.fwd      = (r_fill == '0);

    // A pop from an empty ring takes the incoming byte directly, so the RAM
    // is only read when the entry was written in an earlier cycle.
    assign ram_re = i_pop && !o_stat.fwd;

    // Pointer and fill update.
    always_comb begin
        n_head = push ? ptr_inc(r_head) : r_head;
        n_tail = i_pop ? ptr_inc(r_tail) : r_tail;
        n_fill = r_fill;
        if (push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // Ring storage.
    otum_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_head),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_tail),
        .o_rdata (o_rdata)
    );

endmodule

// ===== hdl/otum_sched.sv =====
// Pulse filter, interleave phase, gap timer and telemetry frame sequencer.
// Depends on otum_pkg; takes ring status from otum_ring.

module otum_sched
    import otum_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_acc,
    input  logic             i_pulse_level,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_tx_ready,
    input  logic             i_gap_tick,
    input  logic [TS_W-1:0]  i_timestamp,
    input  t_ring_stat       i_stat,
    output logic             o_pop,
    output logic             o_sent,
    output logic             o_from_ram,
    output logic [7:0]       o_byte
);

    logic [7:0]         r_frame_gap;
    logic [3:0]         r_ratio;
    logic [2:0]         r_hist;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_frame_cnt;
    logic [TS_W-1:0]    r_frame_ts;
    logic [2:0]         r_fidx;
    logic [3:0]         r_phase;
    logic [7:0]         r_gap;

    logic [2:0]         n_hist;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] n_frame_cnt;
    logic [TS_W-1:0]    n_frame_ts;
    logic [2:0]         n_fidx;
    logic [3:0]         n_phase;
    logic [7:0]         n_gap;
    logic [3:0]         phase_inc;
    logic [2:0]         fidx_use;
    logic               sent;
    logic               cleared;
    logic               pop;
    logic               rebuild;
    logic [7:0]         byte_sel;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_gap <= GAP_RESET;
            r_ratio     <= RATIO_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_GAP:  r_frame_gap <= i_cfg_data;
                CFG_PASS_RATIO: r_ratio     <= i_cfg_data[3:0];
                default:        r_frame_gap <= r_frame_gap;
            endcase
        end
    end

    // Next state of the poll, evaluated for the word at the input.
    always_comb begin
        // Pulse filter: a change that held for two samples after a steady level.
        n_hist  = {r_hist[1:0], i_pulse_level};
        n_count = r_count;
        if ((i_pulse_level != r_hist[1]) && (r_hist[0] == i_pulse_level) &&
            (r_hist[1] == r_hist[2])) begin
            n_count = r_count + 1'b1;
        end

        // Transmit decision.
        phase_inc   = r_phase + 1'b1;
        n_phase     = r_phase;
        n_gap       = r_gap;
        n_fidx      = r_fidx;
        n_frame_cnt = r_frame_cnt;
        n_frame_ts  = r_frame_ts;
        sent        = 1'b0;
        cleared     = 1'b0;
        if (i_tx_ready) begin
            if (i_stat.nonempty) begin
                n_phase = (phase_inc == r_ratio) ? 4'd0 : phase_inc;
                sent    = 1'b1;
            end else begin
                n_phase = 4'd0;
                if (r_gap >= r_frame_gap) begin
                    if (r_fidx >= FRAME_LEN) begin
                        n_gap   = 8'd0;
                        cleared = 1'b1;
                    end
                    sent = 1'b1;
                end
            end
        end

        // Byte source: ring on a nonzero phase, frame otherwise.
        pop      = sent && (n_phase != 4'd0);
        rebuild  = sent && !pop && (r_fidx >= FRAME_LEN);
        fidx_use = rebuild ? 3'd0 : r_fidx;
        if (rebuild) begin
            n_frame_cnt = n_count;
            n_frame_ts  = i_timestamp;
        end
        if (sent && !pop) begin
            n_fidx = fidx_use + 1'b1;
        end
        byte_sel = 8'd0;
        if (sent) begin
            if (pop) begin
                byte_sel = i_stat.fwd ? i_rx_byte : 8'd0;
            end else begin
                byte_sel = frame_byte(n_frame_cnt, n_frame_ts, fidx_use);
            end
        end

        // Gap timer saturates; a tick on the clearing poll is lost.
        if (i_gap_tick && !cleared && (r_gap < GAP_MAX)) begin
            n_gap = r_gap + 1'b1;
        end
    end

    // Poll state advances only when a word is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_count     <= '0;
            r_frame_cnt <= '0;
            r_frame_ts  <= '0;
            r_fidx      <= '0;
            r_phase     <= '0;
            r_gap       <= '0;
        end else if (i_acc) begin
            r_hist      <= n_hist;
            r_count     <= n_count;
            r_frame_cnt <= n_frame_cnt;
            r_frame_ts  <= n_frame_ts;
            r_fidx      <= n_fidx;
            r_phase     <= n_phase;
            r_gap       <= n_gap;
        end
    end

    assign o_pop      = i_acc && pop;
    assign o_sent     = sent;
    assign o_from_ram = pop && !i_stat.fwd;
    assign o_byte     = byte_sel;

endmodule

// ===== hdl/odometer_telemetry_uart_mux.sv =====
// Top level of the odometer telemetry UART mux: handshakes and output pipeline.
// Depends on otum_pkg, otum_ring and otum_sched.

// Each input word is one poll of the pulse pin, the receiver and the
// transmitter, and yields exactly one output word. A new word is accepted
// every clock cycle while the output is not stalled; each word waits in stage A
// for the ring RAM read, then moves to the output register, stage B. The single
// ring RAM port pair (one write, one registered read per cycle) sets that rate.
// Received bytes are held in a 1024-entry ring; no clearing pass is needed
// after reset, and configuration writes are always ready.

module odometer_telemetry_uart_mux
    import otum_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // Configuration write channel.
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [0:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    // Input word channel.
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_pulse_level,
    input  logic            i_rx_valid,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_tx_ready,
    input  logic            i_gap_tick,
    input  logic [TS_W-1:0] i_timestamp,
    // Output word channel.
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_tx_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_rx_dropped
);

    t_ring_stat ring_stat;
    logic [7:0] ram_rdata;
    logic       acc;
    logic       in_ready;
    logic       a_move;
    logic       pop;
    logic       sent;
    logic       from_ram;
    logic [7:0] sched_byte;

    logic       r_a_valid;
    logic       r_a_sent;
    logic       r_a_from_ram;
    logic [7:0] r_a_byte;
    logic       r_a_drop;
    logic       r_b_valid;
    logic       r_b_sent;
    logic [7:0] r_b_byte;
    logic       r_b_drop;

    // Handshakes: stage A advances when the output register is free or taken.
    assign o_cfg_ready = 1'b1;
    assign a_move      = !r_b_valid || !i_out_stall;
    assign in_ready    = !r_a_valid || a_move;
    assign o_in_stall  = !in_ready;
    assign acc         = i_in_valid && in_ready;

    otum_ring u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .i_pop      (pop),
        .o_stat     (ring_stat),
        .o_rdata    (ram_rdata)
    );

    otum_sched u_sched (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_acc         (acc),
        .i_pulse_level (i_pulse_level),
        .i_rx_byte     (i_rx_byte),
        .i_tx_ready    (i_tx_ready),
        .i_gap_tick    (i_gap_tick),
        .i_timestamp   (i_timestamp),
        .i_stat        (ring_stat),
        .o_pop         (pop),
        .o_sent        (sent),
        .o_from_ram    (from_ram),
        .o_byte        (sched_byte)
    );

    // Stage A: word waits here while the ring RAM read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_ready) begin
            r_a_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_sent     <= sent;
            r_a_from_ram <= from_ram;
            r_a_byte     <= sched_byte;
            r_a_drop     <= ring_stat.dropped;
        end
    end

    // Stage B: output register; the RAM data is captured on the way in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move && r_a_valid) begin
            r_b_sent <= r_a_sent;
            r_b_byte <= r_a_from_ram ? ram_rdata : r_a_byte;
            r_b_drop <= r_a_drop;
        end
    end

    assign o_out_valid  = r_b_valid;
    assign o_tx_valid   = r_b_sent;
    assign o_tx_byte    = r_b_byte;
    assign o_rx_dropped = r_b_drop;

    // The input is only held off while stage A is occupied.
    a_stall_needs_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid)
        else $error("input stalled with stage A empty");

    // A pop is only issued when the ring has data for this word.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> ring_stat.nonempty)
        else $error("ring pop without data");

    // RAM data waiting in stage A must not change before it is captured.
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_from_ram && !a_move) |=> $stable(ram_rdata))
        else $error("ring read data changed while stage A held it");

    // A word that sends nothing carries a zero byte.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && a_move && !r_a_sent) |=> (o_tx_byte == 8'd0))
        else $error("nonzero byte on a word that sends nothing");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the odometer telemetry UART mux.
// Depends on otum_pkg and the odometer_telemetry_uart_mux RTL; nothing else.
`timescale 1ns / 100ps

module tb_top;
    import otum_pkg::*;

    // One poll as it is offered on the input channel.
    typedef struct packed {
        logic        pulse;
        logic        rxv;
        logic [7:0]  rxb;
        logic        txr;
        logic        tick;
        logic [15:0] ts;
    } t_poll;

    // One output word as it leaves the block.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
    } t_tx_word;

    typedef enum logic {
        ROW_POLL,
        ROW_CFG
    } t_row_kind;

    // One line of the directed table.
    typedef struct {
        t_row_kind  kind;
        t_poll      p;
        int         reps;
        bit         square;
        bit         typed;
        t_tx_word   want;
        t_cfg_reg   idx;
        logic [7:0] val;
    } t_plan_row;

    localparam t_tx_word QUIET_WORD = t_tx_word'{1'b0, 8'h00, 1'b0};

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    t_cfg_reg          i_cfg_index   = CFG_FRAME_GAP;
    logic [7:0]        i_cfg_data    = 8'h00;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic              i_pulse_level = 1'b0;
    logic              i_rx_valid    = 1'b0;
    logic [7:0]        i_rx_byte     = 8'h00;
    logic              i_tx_ready    = 1'b0;
    logic              i_gap_tick    = 1'b0;
    logic [TS_W-1:0]   i_timestamp   = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic              o_tx_valid;
    logic [7:0]        o_tx_byte;
    logic              o_rx_dropped;

    // Predicted block state and configuration.
    logic [7:0]        ring_mem [RING_DEPTH];
    int                wr_ptr;
    int                rd_ptr;
    int                ring_cnt;
    logic [11:0]       odo_count;
    logic [2:0]        pin_hist;
    logic [7:0]        frame_q [0:5];
    logic [2:0]        frame_pos;
    logic [3:0]        phase_q;
    logic [7:0]        gap_q;
    logic [7:0]        gap_cfg;
    logic [3:0]        ratio_cfg;

    t_tx_word          tx_words_due [$];
    t_plan_row         plan [$];
    int                mismatches = 0;
    bit                calm       = 1'b0;
    bit                want_hold  = 1'b0;
    bit                hold_done  = 1'b0;
    int                hold_left  = 0;

    odometer_telemetry_uart_mux DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pulse_level (i_pulse_level),
        .i_rx_valid    (i_rx_valid),
        .i_rx_byte     (i_rx_byte),
        .i_tx_ready    (i_tx_ready),
        .i_gap_tick    (i_gap_tick),
        .i_timestamp   (i_timestamp),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_rx_dropped  (o_rx_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Build the six frame bytes from the current count and a timestamp.
    function automatic void load_frame(input logic [15:0] stamp);
        logic [7:0] chk;
        frame_q[0] = {2'b11, odo_count[11:6]};
        frame_q[1] = {2'b11, odo_count[5:0]};
        frame_q[2] = {4'b1100, stamp[15:12]};
        frame_q[3] = {2'b11, stamp[11:6]};
        frame_q[4] = {2'b11, stamp[5:0]};
        chk = frame_q[0] ^ frame_q[1] ^ frame_q[2] ^ frame_q[3] ^ frame_q[4];
        frame_q[5] = {2'b10, chk[5:0]};
        frame_pos = '0;
    endfunction

    function automatic void reset_model();
        wr_ptr    = 0;
        rd_ptr    = 0;
        ring_cnt  = 0;
        odo_count = '0;
        pin_hist  = '0;
        load_frame(16'h0000);
        phase_q   = '0;
        gap_q     = '0;
        gap_cfg   = GAP_RESET;
        ratio_cfg = RATIO_RESET;
    endfunction

    // Advance the predicted state by one poll and return the word it yields.
    function automatic t_tx_word predict_tx_word(input t_poll p);
        logic       s1;
        logic       s2;
        logic       s3;
        logic       sent;
        logic       cleared;
        logic       dropped;
        logic [7:0] b;
        t_tx_word   w;
        s1      = pin_hist[0];
        s2      = pin_hist[1];
        s3      = pin_hist[2];
        sent    = 1'b0;
        cleared = 1'b0;
        dropped = 1'b0;
        b       = 8'h00;

        // A level change counts once it has held for two samples.
        if (p.pulse != s2 && s1 == p.pulse && s2 == s3) begin
            odo_count = odo_count + 1'b1;
        end
        pin_hist = {s2, s1, p.pulse};

        // A full ring drops the incoming byte.
        if (p.rxv) begin
            if (ring_cnt >= RING_DEPTH) begin
                dropped = 1'b1;
            end else begin
                ring_mem[wr_ptr] = p.rxb;
                wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
                ring_cnt++;
            end
        end

        // Interleave ring bytes with frame bytes, or send idle frames after the gap.
        if (p.txr) begin
            if (ring_cnt != 0) begin
                phase_q = phase_q + 1'b1;
                if (phase_q == ratio_cfg) begin
                    phase_q = '0;
                end
                sent = 1'b1;
            end else begin
                phase_q = '0;
                if (gap_q >= gap_cfg) begin
                    if (frame_pos >= FRAME_LEN) begin
                        gap_q   = '0;
                        cleared = 1'b1;
                    end
                    sent = 1'b1;
                end
            end
            if (sent) begin
                if (phase_q != 0) begin
                    b = ring_mem[rd_ptr];
                    rd_ptr = (rd_ptr == RING_DEPTH - 1) ? 0 : rd_ptr + 1;
                    ring_cnt--;
                end else begin
                    if (frame_pos >= FRAME_LEN) begin
                        load_frame(p.ts);
                    end
                    b = frame_q[frame_pos];
                    frame_pos = frame_pos + 1'b1;
                end
            end
        end

        // The gap timer saturates, and loses its tick when it is cleared.
        if (p.tick && !cleared && gap_q != GAP_MAX) begin
            gap_q = gap_q + 1'b1;
        end

        w.tx_valid   = sent;
        w.tx_byte    = b;
        w.rx_dropped = dropped;
        return w;
    endfunction

    function automatic void poll_row(input int reps, input bit square, input logic pulse,
                                     input logic rxv, input logic [7:0] rxb,
                                     input logic txr, input logic tick,
                                     input logic [15:0] ts, input bit typed,
                                     input t_tx_word want);
        t_plan_row r;
        r.kind   = ROW_POLL;
        r.p      = t_poll'{pulse, rxv, rxb, txr, tick, ts};
        r.reps   = reps;
        r.square = square;
        r.typed  = typed;
        r.want   = want;
        r.idx    = CFG_FRAME_GAP;
        r.val    = 8'h00;
        plan.push_back(r);
    endfunction

    function automatic void cfg_row(input t_cfg_reg idx, input logic [7:0] val);
        t_plan_row r;
        r.kind   = ROW_CFG;
        r.p      = '0;
        r.reps   = 0;
        r.square = 1'b0;
        r.typed  = 1'b0;
        r.want   = QUIET_WORD;
        r.idx    = idx;
        r.val    = val;
        plan.push_back(r);
    endfunction

    // Offer one poll, wait for it to be taken, then record what it should yield.
    task automatic offer_poll(input t_poll p, input bit typed, input t_tx_word want);
        t_tx_word got;
        int       gap_len;
        if (!calm && $urandom_range(0, 99) < 8) begin
            gap_len = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap_len) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pulse_level <= p.pulse;
        i_rx_valid    <= p.rxv;
        i_rx_byte     <= p.rxb;
        i_tx_ready    <= p.txr;
        i_gap_tick    <= p.tick;
        i_timestamp   <= p.ts;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = predict_tx_word(p);
        tx_words_due.push_back(typed ? want : got);
    endtask

    // Stop offering and let every outstanding word drain out of the pipeline.
    task automatic go_quiet();
        i_in_valid <= 1'b0;
        while (tx_words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_FRAME_GAP) begin
            gap_cfg = val;
        end else begin
            ratio_cfg = val[3:0];
        end
    endtask

    task automatic set_mode(input logic [7:0] gap, input logic [3:0] ratio);
        go_quiet();
        write_reg(CFG_FRAME_GAP, gap);
        write_reg(CFG_PASS_RATIO, {4'h0, ratio});
        i_cfg_valid <= 1'b0;
    endtask

    // Output side: check each accepted word and drive the stall.
    always @(posedge i_clk) begin : out_side
        t_tx_word due;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (tx_words_due.size() == 0) begin
                    $error("output word with nothing expected");
                    mismatches++;
                end else begin
                    due = tx_words_due.pop_front();
                    if (o_tx_valid !== due.tx_valid) begin
                        $error("tx_valid: expected %0b, got %0b", due.tx_valid, o_tx_valid);
                        mismatches++;
                    end
                    if (o_tx_byte !== due.tx_byte) begin
                        $error("tx_byte: expected %02h, got %02h", due.tx_byte, o_tx_byte);
                        mismatches++;
                    end
                    if (o_rx_dropped !== due.rx_dropped) begin
                        $error("rx_dropped: expected %0b, got %0b",
                               due.rx_dropped, o_rx_dropped);
                        mismatches++;
                    end
                end
            end
            // One long hold-off so the block backs up into its input.
            if (want_hold && !hold_done) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 8);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_poll      p;
        int         r;
        int         k;
        int         ph;
        int         n;
        int         rx_pct;
        int         tx_pct;
        int         tick_pct;
        logic [7:0] gap;
        logic [3:0] ratio;
        logic       pin;

        reset_model();

        // Reset defaults: nothing goes out before the gap, then the reset frame.
        poll_row(1, 0, 0, 0, 8'h00, 0, 0, 16'h0000, 1, QUIET_WORD);
        poll_row(5, 0, 0, 0, 8'h00, 1, 0, 16'h0000, 1, QUIET_WORD);
        cfg_row(CFG_FRAME_GAP, 8'd1);
        poll_row(1, 0, 0, 0, 8'h00, 0, 1, 16'h0000, 1, QUIET_WORD);
        poll_row(5, 0, 0, 0, 8'h00, 1, 0, 16'h0000, 1, t_tx_word'{1'b1, 8'hC0, 1'b0});
        poll_row(1, 0, 0, 0, 8'h00, 1, 0, 16'h0000, 1, t_tx_word'{1'b1, 8'h80, 1'b0});
        // Next frame starts with a maximal timestamp and restarts the gap.
        poll_row(1, 0, 0, 0, 8'h00, 1, 0, 16'hFFFF, 0, QUIET_WORD);
        poll_row(20, 0, 0, 0, 8'h00, 1, 1, 16'h0000, 0, QUIET_WORD);
        // Clean edges, then a one-sample glitch.
        poll_row(3, 0, 1, 0, 8'h00, 0, 0, 16'h0000, 0, QUIET_WORD);
        poll_row(3, 0, 0, 0, 8'h00, 0, 0, 16'h0000, 0, QUIET_WORD);
        poll_row(1, 0, 1, 0, 8'h00, 0, 0, 16'h0000, 0, QUIET_WORD);
        poll_row(2, 0, 0, 0, 8'h00, 0, 0, 16'h0000, 0, QUIET_WORD);
        // Ratio lowered below the running phase, then a ratio of zero.
        cfg_row(CFG_PASS_RATIO, 8'd15);
        poll_row(20, 0, 0, 1, 8'hFF, 0, 0, 16'h0000, 0, QUIET_WORD);
        poll_row(10, 0, 0, 0, 8'h00, 1, 0, 16'h0000, 0, QUIET_WORD);
        cfg_row(CFG_PASS_RATIO, 8'd2);
        poll_row(12, 0, 0, 1, 8'h00, 1, 0, 16'h0000, 0, QUIET_WORD);
        cfg_row(CFG_PASS_RATIO, 8'd0);
        poll_row(20, 0, 0, 1, 8'h5A, 1, 0, 16'h0000, 0, QUIET_WORD);
        cfg_row(CFG_PASS_RATIO, 8'd3);
        // Drain the ring, then a square wave on the pin steps the count.
        poll_row(30, 0, 0, 0, 8'h00, 1, 1, 16'h5555, 0, QUIET_WORD);
        poll_row(40, 1, 0, 0, 8'h00, 0, 0, 16'h0000, 0, QUIET_WORD);
        poll_row(30, 0, 0, 0, 8'h00, 1, 1, 16'h0FC0, 0, QUIET_WORD);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].kind == ROW_CFG) begin
                go_quiet();
                write_reg(plan[r].idx, plan[r].val);
                i_cfg_valid <= 1'b0;
            end else begin
                for (k = 0; k < plan[r].reps; k++) begin
                    p = plan[r].p;
                    if (plan[r].square) begin
                        p.pulse = k[1];
                    end
                    offer_poll(p, plan[r].typed, plan[r].want);
                end
            end
        end

        // Random phases, each under its own register setting.
        pin = 1'b0;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    gap = 8'd1;   ratio = 4'd1;  n = 60;
                    rx_pct = 40;  tx_pct = 85;   tick_pct = 50;
                end
                1: begin
                    gap = 8'd255; ratio = 4'd15; n = 50;
                    rx_pct = 4;   tx_pct = 70;   tick_pct = 95;
                end
                default: begin
                    gap = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 24));
                    ratio    = 4'($urandom_range(1, 15));
                    n        = 25;
                    rx_pct   = $urandom_range(10, 70);
                    tx_pct   = $urandom_range(30, 95);
                    tick_pct = $urandom_range(30, 90);
                end
            endcase
            set_mode(gap, ratio);
            calm <= (ph == 0);
            if (ph == 3) begin
                want_hold <= 1'b1;
            end
            for (k = 0; k < n; k++) begin
                // Sender waits here for every outstanding word.
                if (ph == 4 && k == 12) begin
                    go_quiet();
                end
                if ($urandom_range(0, 99) < 30) begin
                    pin = ~pin;
                end
                p.pulse = pin;
                p.rxv   = ($urandom_range(0, 99) < rx_pct);
                p.rxb   = 8'($urandom_range(0, 255));
                p.txr   = ($urandom_range(0, 99) < tx_pct);
                p.tick  = ($urandom_range(0, 99) < tick_pct);
                p.ts    = 16'($urandom_range(0, 65535));
                offer_poll(p, 1'b0, QUIET_WORD);
            end
        end

        go_quiet();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== odometer_telemetry_uart_mux.f =====
hdl/otum_pkg.sv
hdl/otum_ram.sv
hdl/otum_ring.sv
hdl/otum_sched.sv
hdl/odometer_telemetry_uart_mux.sv
dv/tb_top.sv
